@@ design/padr_pkg.sv @@
// ----------------------------------------------------------------------------
// padr_pkg: shared types and constants for the phase-angle dimmer ramp
// Holds payload structs, the register map, reset values and timer sizes.
// ----------------------------------------------------------------------------
package padr_pkg;

   localparam int unsigned TimerWidth   = 16;
   localparam int unsigned DelayWidth   = 16;
   localparam int unsigned CmpWidth     = TimerWidth + DelayWidth;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [TimerWidth-1:0] TimerMax = '1;

   localparam logic [DelayWidth-1:0] StartDelayReset      = DelayWidth'(6000);
   localparam logic [DelayWidth-1:0] MinDelayReset        = DelayWidth'(2000);
   localparam logic [DelayWidth-1:0] DelayStepReset       = DelayWidth'(100);
   localparam logic [DelayWidth-1:0] RampIntervalReset    = DelayWidth'(10000);
   localparam logic [DelayWidth-1:0] CrossingLockoutReset = DelayWidth'(5000);

   typedef enum logic [2:0] {
      REG_START_DELAY      = 3'd0,
      REG_MIN_DELAY        = 3'd1,
      REG_DELAY_STEP       = 3'd2,
      REG_RAMP_INTERVAL    = 3'd3,
      REG_CROSSING_LOCKOUT = 3'd4
   } padr_reg_type;

   typedef struct packed {
      logic zero_cross;
      logic alarm_enabled;
      logic restart_ramp;
   } padr_req_type;

   typedef struct packed {
      logic                  triac_gate;
      logic [DelayWidth-1:0] current_delay;
      logic                  ramp_done;
   } padr_rsp_type;

   typedef struct packed {
      logic [DelayWidth-1:0] start_delay;
      logic [DelayWidth-1:0] min_delay;
      logic [DelayWidth-1:0] delay_step;
      logic [DelayWidth-1:0] ramp_interval;
      logic [DelayWidth-1:0] crossing_lockout;
   } padr_cfg_type;

   typedef struct packed {
      logic [DelayWidth-1:0] fire_delay;
      logic                  ramp_finished;
      logic [TimerWidth-1:0] since_crossing;
      logic [TimerWidth-1:0] since_ramp_step;
      logic [TimerWidth-1:0] fire_countdown;
      logic                  fire_pending;
      logic                  gate_level;
   } padr_state_type;

endpackage

@@ design/phase_angle_dimmer_ramp.sv @@
// ----------------------------------------------------------------------------
// phase_angle_dimmer_ramp: triac phase-angle dimmer with brightening ramp
// Flow: a request transfer is registered in the input stage, processed by
//   padr_step, and its result is registered in the result register.
// Throughput: one tick per cycle; the input stage and the result register
//   each advance whenever the next stage is free or being emptied.
// Reset: synchronous, active high; registers return to their documented
//   defaults and the dimmer state to its idle, saturated-counter condition.
// ----------------------------------------------------------------------------
module phase_angle_dimmer_ramp (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  padr_pkg::padr_req_type            req_data,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output padr_pkg::padr_rsp_type            rsp_data,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [padr_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [padr_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [padr_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                              csr_pready
);
   import padr_pkg::*;

   padr_cfg_type   cfg;

   // input stage: holds one accepted tick
   logic           in_valid_ff;
   logic           in_valid_in;
   padr_req_type   in_item_ff;

   // result register
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   padr_rsp_type   rsp_item_ff;

   // dimmer state, updated once per processed tick
   padr_state_type state_ff;
   padr_state_type state_in;
   padr_rsp_type   step_result;

   logic           advance;
   logic           req_xfer;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   padr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------------------------------------------------------------
   // Handshake: the held tick moves into the result register when that
   // register is empty or its transfer happens this cycle. The input stage
   // takes a new tick whenever it is empty or being drained.
   // ---------------------------------------------------------------------
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // ---------------------------------------------------------------------
   // One-tick state update between the input stage and the result register
   // ---------------------------------------------------------------------
   padr_step u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .result     (step_result)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // dimmer state: commit only when a tick advances
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.fire_delay      <= StartDelayReset;
         state_ff.ramp_finished   <= 1'b0;
         state_ff.since_crossing  <= TimerMax;
         state_ff.since_ramp_step <= TimerMax;
         state_ff.fire_countdown  <= '0;
         state_ff.fire_pending    <= 1'b0;
         state_ff.gate_level      <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // payload registers: hold until the next transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // gate up and fire still pending never coexist
   a_gate_vs_pending: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.gate_level && state_ff.fire_pending))
      else $error("gate high while a fire is pending");

   // a pending fire always has time left on its countdown
   a_pending_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.fire_pending |-> (state_ff.fire_countdown != '0))
      else $error("fire pending with empty countdown");

   // a tick that advances shows up as a result on the next cycle
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed tick produced no result");

   // an empty input stage always takes a new tick
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

endmodule

@@ design/padr_csr.sv @@
// ----------------------------------------------------------------------------
// padr_csr: configuration register file
// APB-style write and read access to the five timing registers.
// ----------------------------------------------------------------------------
module padr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [padr_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [padr_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [padr_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                               csr_pready,
   output padr_pkg::padr_cfg_type             cfg
);
   import padr_pkg::*;

   padr_cfg_type          cfg_ff;
   padr_cfg_type          cfg_in;
   padr_reg_type          reg_sel;
   logic                  wr_en;
   logic [DelayWidth-1:0] wr_data;
   logic [DelayWidth-1:0] rd_data;

   assign reg_sel    = padr_reg_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wr_data    = csr_pwdata[DelayWidth-1:0];
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_START_DELAY:      cfg_in.start_delay      = wr_data;
            REG_MIN_DELAY:        cfg_in.min_delay        = wr_data;
            REG_DELAY_STEP:       cfg_in.delay_step       = wr_data;
            REG_RAMP_INTERVAL:    cfg_in.ramp_interval    = wr_data;
            REG_CROSSING_LOCKOUT: cfg_in.crossing_lockout = wr_data;
            default:              cfg_in = cfg_ff;  // drop writes past the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay      <= StartDelayReset;
         cfg_ff.min_delay        <= MinDelayReset;
         cfg_ff.delay_step       <= DelayStepReset;
         cfg_ff.ramp_interval    <= RampIntervalReset;
         cfg_ff.crossing_lockout <= CrossingLockoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_START_DELAY:      rd_data = cfg_ff.start_delay;
         REG_MIN_DELAY:        rd_data = cfg_ff.min_delay;
         REG_DELAY_STEP:       rd_data = cfg_ff.delay_step;
         REG_RAMP_INTERVAL:    rd_data = cfg_ff.ramp_interval;
         REG_CROSSING_LOCKOUT: rd_data = cfg_ff.crossing_lockout;
         default:              rd_data = '0;
      endcase
   end

   assign csr_prdata = CsrDataWidth'(rd_data);
   assign cfg        = cfg_ff;

endmodule

@@ design/padr_step.sv @@
// ----------------------------------------------------------------------------
// padr_step: one-tick update of the dimmer state
// Restart, counter advance, ramp step, fire countdown, crossing acceptance.
// ----------------------------------------------------------------------------
module padr_step (
   input  padr_pkg::padr_state_type state,
   input  padr_pkg::padr_req_type   item,
   input  padr_pkg::padr_cfg_type   cfg,
   output padr_pkg::padr_state_type state_next,
   output padr_pkg::padr_rsp_type   result
);
   import padr_pkg::*;

   function automatic logic [TimerWidth-1:0] sat_inc(input logic [TimerWidth-1:0] v);
      return (v == TimerMax) ? v : v + 1'b1;
   endfunction

   // counter has reached the limit, or sits saturated
   function automatic logic reached(input logic [TimerWidth-1:0] count,
                                    input logic [DelayWidth-1:0] limit);
      return (CmpWidth'(count) >= CmpWidth'(limit)) || (count == TimerMax);
   endfunction

   always_comb begin
      padr_state_type        s;
      logic [CmpWidth-1:0]   delay_wide;
      logic [TimerWidth-1:0] load_count;

      s = state;

      if (item.restart_ramp) begin
         s.fire_delay      = cfg.start_delay;
         s.ramp_finished   = 1'b0;
         s.since_ramp_step = TimerMax;
      end

      s.since_crossing  = sat_inc(s.since_crossing);
      s.since_ramp_step = sat_inc(s.since_ramp_step);

      if (item.alarm_enabled && reached(s.since_ramp_step, cfg.ramp_interval)) begin
         s.since_ramp_step = '0;
         if (!s.ramp_finished) begin
            s.fire_delay = (s.fire_delay > cfg.delay_step) ?
                           s.fire_delay - cfg.delay_step : '0;
         end
         if (s.fire_delay <= cfg.min_delay) begin
            s.ramp_finished = 1'b1;
         end
      end

      if (s.fire_pending) begin
         if (s.fire_countdown != '0) begin
            s.fire_countdown = s.fire_countdown - 1'b1;
         end
         if (s.fire_countdown == '0) begin
            s.gate_level   = 1'b1;
            s.fire_pending = 1'b0;
         end
      end

      // clamp the delay to what the countdown can hold
      delay_wide = CmpWidth'(s.fire_delay);
      load_count = (delay_wide > CmpWidth'(TimerMax)) ? TimerMax
                                                      : delay_wide[TimerWidth-1:0];

      if (item.zero_cross && reached(s.since_crossing, cfg.crossing_lockout)) begin
         s.since_crossing = '0;
         s.fire_countdown = load_count;
         s.gate_level     = (load_count == '0);
         s.fire_pending   = (load_count != '0);
      end

      state_next           = s;
      result.triac_gate    = s.gate_level;
      result.current_delay = s.fire_delay;
      result.ramp_done     = s.ramp_finished;
   end

endmodule
